[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define S2_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define S2_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/s2seg_pkg.sv]
// ----------------------------------------------------------------------------
// s2seg_pkg
// Result type, digit constants and the seven-segment glyph table.
// ----------------------------------------------------------------------------
package s2seg_pkg;

	localparam logic [3:0] DIGIT_TOP  = 4'd9;
	localparam logic [3:0] DIGIT_ZERO = 4'd0;

	typedef struct packed {
		logic       is_sign;
		logic       negative;
		logic [6:0] segment_bits;
		logic [3:0] digit_value;
		logic       last;
	} res_t;

	function automatic logic [6:0] glyph(input logic [3:0] d);
		logic [6:0] g;
		unique case (d)
			4'd0: g = 7'h3F;
			4'd1: g = 7'h06;
			4'd2: g = 7'h5B;
			4'd3: g = 7'h4F;
			4'd4: g = 7'h66;
			4'd5: g = 7'h6D;
			4'd6: g = 7'h7D;
			4'd7: g = 7'h07;
			4'd8: g = 7'h7F;
			default: g = 7'h67;
		endcase
		return g;
	endfunction

endpackage

[rtl/s2seg_front.sv]
// ----------------------------------------------------------------------------
// s2seg_front
// Accepts values, splits them into sign and magnitude, and queues them in a
// two-entry buffer for the conversion back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module s2seg_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic                          push,
	output logic                          full,
	output logic                          q_valid,
	input  logic                          q_ready,
	output logic                          q_neg,
	output logic [VALUE_WIDTH-1:0]        q_mag
);

	logic                   neg_mem_q [2];
	logic [VALUE_WIDTH-1:0] mag_mem_q [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             count_q;
	logic                   do_push;
	logic                   do_pop;
	logic                   in_neg;
	logic [VALUE_WIDTH-1:0] in_mag;

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign do_push = push && !full;
	assign do_pop  = q_valid && q_ready;
	assign in_neg  = value[VALUE_WIDTH-1];
	assign in_mag  = in_neg ? (~value + 1'b1) : value;
	assign q_neg   = neg_mem_q[rd_ptr_q];
	assign q_mag   = mag_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			neg_mem_q[wr_ptr_q] <= in_neg;
			mag_mem_q[wr_ptr_q] <= in_mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			priority if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	`S2_ASSERT(a_count_bound, count_q <= 2'd2, "queue count exceeds its depth")
	`S2_ASSERT_IMPL(a_ptr_match, count_q == 2'd0 || count_q == 2'd2, wr_ptr_q == rd_ptr_q,
		"queue pointers disagree with the fill count")

endmodule

[rtl/s2seg_back.sv]
// ----------------------------------------------------------------------------
// s2seg_back
// Converts a magnitude to decimal by shift-add-3, strips leading zeros and
// emits the sign transaction and one digit transaction per decimal place.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module s2seg_back #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_DIGITS  = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_neg,
	input  logic [VALUE_WIDTH-1:0]  in_mag,
	output s2seg_pkg::res_t         res,
	output logic                    empty,
	input  logic                    pop
);

	import s2seg_pkg::*;

	localparam int BCD_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int REM_MAX    = (BCD_DIGITS > MAX_DIGITS) ? BCD_DIGITS : MAX_DIGITS;
	localparam int REM_W      = $clog2(REM_MAX + 1);
	localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic                   neg_q;
	logic                   sign_pend_q;
	logic                   sat_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [REM_W-1:0]       rem_q;
	logic                   out_valid_q;
	res_t                   out_q;

	logic [BCD_W-1:0]       dab;
	logic [3:0]             top_digit;
	logic [3:0]             emit_digit;
	logic                   slot_free;
	logic                   load_sign;
	logic                   load_digit;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			dab[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
				: bcd_q[4*i +: 4];
		end
	end

	assign top_digit  = bcd_q[BCD_W-1 -: 4];
	assign emit_digit = sat_q ? DIGIT_TOP : top_digit;
	assign slot_free  = !out_valid_q || pop;
	assign load_sign  = sign_pend_q && slot_free;
	assign load_digit = (state_q == ST_EMIT) && !sign_pend_q && slot_free;
	assign in_ready   = (state_q == ST_IDLE);
	assign empty      = !out_valid_q;
	assign res        = out_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mag_q <= in_mag;
				neg_q <= in_neg;
				bcd_q <= '0;
			end
			ST_CONV: begin
				bcd_q <= {dab[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
				mag_q <= mag_q << 1;
			end
			ST_SKIP: begin
				if (top_digit == DIGIT_ZERO && rem_q > REM_W'(1)) begin
					bcd_q <= bcd_q << 4;
				end
			end
			ST_EMIT: begin
				if (load_digit) begin
					bcd_q <= bcd_q << 4;
				end
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
		if (load_sign) begin
			out_q <= '{is_sign: 1'b1, negative: neg_q, segment_bits: 7'd0,
				digit_value: DIGIT_ZERO, last: 1'b0};
		end else if (load_digit) begin
			out_q <= '{is_sign: 1'b0, negative: 1'b0, segment_bits: glyph(emit_digit),
				digit_value: emit_digit, last: (rem_q == REM_W'(1))};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sign_pend_q <= 1'b0;
			sat_q       <= 1'b0;
			cnt_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sign_pend_q <= 1'b1;
						cnt_q       <= CNT_W'(VALUE_WIDTH);
						state_q     <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						rem_q   <= REM_W'(BCD_DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (top_digit == DIGIT_ZERO && rem_q > REM_W'(1)) begin
						rem_q <= rem_q - REM_W'(1);
					end else begin
						sat_q <= (rem_q > REM_W'(MAX_DIGITS));
						if (rem_q > REM_W'(MAX_DIGITS)) begin
							rem_q <= REM_W'(MAX_DIGITS);
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_digit) begin
						rem_q <= rem_q - REM_W'(1);
						if (rem_q == REM_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_sign) begin
				sign_pend_q <= 1'b0;
			end
			priority if (load_sign || load_digit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`S2_ASSERT_IMPL(a_digit_range, out_valid_q && !out_q.is_sign,
		out_q.digit_value <= DIGIT_TOP, "digit transaction holds a non-decimal digit")
	`S2_ASSERT_IMPL(a_emit_rem, state_q == ST_EMIT, rem_q != '0,
		"emitting with no digits left")
	`S2_ASSERT_IMPL(a_sign_before_digits, state_q == ST_SKIP || state_q == ST_IDLE,
		!(sign_pend_q && state_q == ST_IDLE), "sign transaction still pending at run end")

endmodule

[rtl/signed_int_to_seven_segment_unit.sv]
// ----------------------------------------------------------------------------
// signed_int_to_seven_segment_unit
// Shows a signed integer as a sign transaction and seven-segment digits.
// ----------------------------------------------------------------------------
// A value is written with push while full is low. Each value yields a sign
// transaction followed by one transaction per decimal digit, most significant
// first, with leading zeros dropped; the final digit has last set. A zero
// shows a single 0, and a magnitude with more than MAX_DIGITS digits shows
// MAX_DIGITS nines. Results are read with pop while empty is low.
// A two-entry queue holds values ahead of the converter. The converter takes
// a value, runs shift-add-3 over its VALUE_WIDTH bits, then drops leading zero
// places, leaves that step and sends one digit at a time; it takes no new
// value until the last digit is sent. A pushed value passes the queue and the
// sign-pending flag before its sign transaction reaches the output register.
// When pop stays low the single output register holds its transaction and
// the converter waits; the queue keeps taking values until it is full. Reset
// empties the queue and the output register and leaves the converter idle.
// ----------------------------------------------------------------------------
module signed_int_to_seven_segment_unit #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_DIGITS  = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic                          push,
	output logic                          full,
	output logic                          is_sign,
	output logic                          negative,
	output logic [6:0]                    segment_bits,
	output logic [3:0]                    digit_value,
	output logic                          last,
	output logic                          empty,
	input  logic                          pop
);

	import s2seg_pkg::*;

	logic                   q_valid;
	logic                   q_ready;
	logic                   q_neg;
	logic [VALUE_WIDTH-1:0] q_mag;
	res_t                   res;

	s2seg_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.value   (value),
		.push    (push),
		.full    (full),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_neg   (q_neg),
		.q_mag   (q_mag)
	);

	s2seg_back #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_neg   (q_neg),
		.in_mag   (q_mag),
		.res      (res),
		.empty    (empty),
		.pop      (pop)
	);

	assign is_sign      = res.is_sign;
	assign negative     = res.negative;
	assign segment_bits = res.segment_bits;
	assign digit_value  = res.digit_value;
	assign last         = res.last;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for signed_int_to_seven_segment_unit
// Pushes signed 32-bit values through the unit and predicts, for each one, a
// sign transaction followed by seven-segment digit transactions. A scoreboard
// compares every popped transaction field by field with the oldest prediction.
// Corner values come first, then random values under three idling mixes, one
// long output stall and a drain between phases.
// ----------------------------------------------------------------------------
module testbench;
	import s2seg_pkg::*;

	localparam int VALUE_BITS   = 32;
	localparam int DIGIT_LIMIT  = 10;
	localparam int RADIX        = 10;
	localparam int RANDOM_ITEMS = 148;
	localparam int LONG_STALL   = 400;
	localparam int SETTLE       = 60;
	localparam int CYCLE_LIMIT  = 400000;

	class display_scoreboard;
		res_t expected_glyphs[$];
		int   errors;
		int   values_seen;
		int   negatives_seen;
		int   transactions_checked;

		function new();
			errors = 0;
			values_seen = 0;
			negatives_seen = 0;
			transactions_checked = 0;
		endfunction

		function logic [6:0] segments_for(logic [3:0] d);
			logic [6:0] s;
			case (d)
				4'd0: s = 7'h3F;
				4'd1: s = 7'h06;
				4'd2: s = 7'h5B;
				4'd3: s = 7'h4F;
				4'd4: s = 7'h66;
				4'd5: s = 7'h6D;
				4'd6: s = 7'h7D;
				4'd7: s = 7'h07;
				4'd8: s = 7'h7F;
				default: s = 7'h67;
			endcase
			return s;
		endfunction

		function void note_value(logic [VALUE_BITS-1:0] v);
			logic [VALUE_BITS-1:0] mag;
			logic [3:0]            digits[$];
			logic [3:0]            d;
			res_t                  r;
			mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
			values_seen++;
			if (v[VALUE_BITS-1])
				negatives_seen++;
			r = '0;
			r.is_sign = 1'b1;
			r.negative = v[VALUE_BITS-1];
			expected_glyphs.push_back(r);
			do begin
				d = 4'(mag % RADIX);
				digits.push_front(d);
				mag = mag / RADIX;
			end while (mag != 0);
			if (digits.size() > DIGIT_LIMIT) begin
				digits.delete();
				repeat (DIGIT_LIMIT) digits.push_back(DIGIT_TOP);
			end
			foreach (digits[i]) begin
				r = '0;
				r.segment_bits = segments_for(digits[i]);
				r.digit_value = digits[i];
				r.last = (i == digits.size() - 1);
				expected_glyphs.push_back(r);
			end
		endfunction

		function void report_field(string field, logic [6:0] want, logic [6:0] got);
			$display("%0t: mismatch on %s: expected %h, actual %h", $time, field, want, got);
			errors++;
		endfunction

		function void check_digit(res_t got);
			res_t want;
			if (expected_glyphs.size() == 0) begin
				$display("%0t: transaction with nothing expected: actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_glyphs.pop_front();
			transactions_checked++;
			if (got.is_sign !== want.is_sign)
				report_field("is_sign", want.is_sign, got.is_sign);
			if (got.negative !== want.negative)
				report_field("negative", want.negative, got.negative);
			if (got.segment_bits !== want.segment_bits)
				report_field("segment_bits", want.segment_bits, got.segment_bits);
			if (got.digit_value !== want.digit_value)
				report_field("digit_value", want.digit_value, got.digit_value);
			if (got.last !== want.last)
				report_field("last", want.last, got.last);
		endfunction

		function int pending();
			return expected_glyphs.size();
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic signed [VALUE_BITS-1:0] value = '0;
	logic                         push = 1'b0;
	logic                         full;
	logic                         is_sign;
	logic                         negative;
	logic [6:0]                   segment_bits;
	logic [3:0]                   digit_value;
	logic                         last;
	logic                         empty;
	logic                         pop = 1'b0;

	display_scoreboard sb = new();
	int send_idle_pct = 0;
	int take_idle_pct = 0;
	int stall_requests = 0;
	int stalls_served = 0;
	int stall_left = 0;
	int cycles = 0;

	signed_int_to_seven_segment_unit #(
		.VALUE_WIDTH(VALUE_BITS),
		.MAX_DIGITS(DIGIT_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.value(value),
		.push(push),
		.full(full),
		.is_sign(is_sign),
		.negative(negative),
		.segment_bits(segment_bits),
		.digit_value(digit_value),
		.last(last),
		.empty(empty),
		.pop(pop)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_digit({is_sign, negative, segment_bits, digit_value, last});
		if (stalls_served != stall_requests) begin
			stalls_served <= stalls_served + 1;
			stall_left <= LONG_STALL;
			pop <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= take_idle_pct);
		end
	end

	task automatic offer_value(input logic [VALUE_BITS-1:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			value <= $urandom;
			@(posedge clk);
		end
		value <= v;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_value(v);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [VALUE_BITS-1:0] random_value();
		logic [VALUE_BITS-1:0] mag;
		logic [VALUE_BITS-1:0] decade;
		int                    shape;
		int                    k;
		shape = $urandom_range(0, 9);
		decade = 1;
		if (shape < 3)
			return $urandom;
		if (shape < 7) begin
			mag = $urandom >> $urandom_range(0, VALUE_BITS - 1);
		end else begin
			k = $urandom_range(0, 9);
			repeat (k) decade = decade * RADIX;
			mag = decade + $urandom_range(0, 2) - 1;
		end
		return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
	endfunction

	initial begin
		logic [VALUE_BITS-1:0] corner_values[$];
		int                    per_phase;
		corner_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd7, 32'd9, 32'd10,
			-32'sd10, 32'd42, 32'd99, 32'd100, -32'sd101, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0001, 32'd1234567890, -32'sd987654321,
			32'd1000000000, 32'd999999999, 32'd8765, -32'sd65536,
			32'h5555_5555, 32'hAAAA_AAAA};
		per_phase = RANDOM_ITEMS / 3;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 29;
		take_idle_pct <= 86;
		foreach (corner_values[i])
			offer_value(corner_values[i]);
		repeat (per_phase) offer_value(random_value());
		wait_drained();

		send_idle_pct = 86;
		take_idle_pct <= 29;
		repeat (per_phase) offer_value(random_value());
		wait_drained();

		send_idle_pct = 0;
		take_idle_pct <= 0;
		stall_requests <= stall_requests + 1;
		repeat (RANDOM_ITEMS - 2 * per_phase) offer_value(random_value());
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d values (%0d negative) and %0d checked transactions.",
			sb.values_seen, sb.negatives_seen, sb.transactions_checked);
		$display("Both sides idled in turn, then streamed, with one long output stall.");
		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
